// ===== design/cscan_pkg.sv =====
package cscan_pkg;

  // fixed field widths
  localparam int TRACK_W = 16;
  localparam int TOTAL_W = 22;
  localparam int COUNT_W = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_REQUESTS = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

  // reset value of the track count register
  localparam logic [COUNT_W-1:0] COUNT_RESET = 17'h10000;

  typedef struct packed {
    logic [TRACK_W-1:0] request_track;
    logic               last_request;
  } in_word_t;

  typedef struct packed {
    logic [TRACK_W-1:0] visited_track;
    logic [TRACK_W-1:0] step_distance;
    logic [TOTAL_W-1:0] total_distance;
    logic               last_result;
  } out_word_t;

  // control that travels with a track read during the walk
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } walk_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_START,
    S_INS_CMP,
    S_SRCH_START,
    S_SRCH_CMP,
    S_EMIT,
    S_DRAIN
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_REQ,
    PH_ZERO,
    PH_HEAD,
    PH_END
  } ins_phase_t;

endpackage

// ===== design/cscan_ram.sv =====
module cscan_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 35
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/cscan_dist.sv =====
module cscan_dist import cscan_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  walk_ctl_t          ctl,
  input  logic [TRACK_W-1:0] cur,
  output logic               out_strobe,
  output out_word_t          out_data
);

  logic [TRACK_W-1:0] prev_r;
  logic [TOTAL_W-1:0] total_r;
  logic               strobe_r;
  out_word_t          data_r;

  logic [TRACK_W-1:0] diff;
  logic [TRACK_W-1:0] step_len;
  logic [TOTAL_W-1:0] total_nxt;

  always_comb begin
    diff      = (cur >= prev_r) ? (cur - prev_r) : (prev_r - cur);
    step_len  = ctl.first ? '0 : diff;
    total_nxt = (ctl.first ? '0 : total_r) + TOTAL_W'(step_len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl.valid;
    end
    if (ctl.valid) begin
      prev_r  <= cur;
      total_r <= total_nxt;
      data_r  <= '{visited_track: cur, step_distance: step_len,
                   total_distance: total_nxt, last_result: ctl.last};
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule

// ===== design/cscan_disk_request_order.sv =====
// a request that is not last keeps busy high while the larger stored tracks are shifted up
// to make room; the last request adds three more sorted insertions (0, head, end), a search
// for the head and the walk
// throughput: one item at a time, set by the single ram port pair and the shared compare;
// results leave one word per cycle during the walk; reset: synchronous active-low rst_n
// clears control, count and config; the store is not cleared
module cscan_disk_request_order import cscan_pkg::*; #(
  parameter int MAX_REQUESTS = DEF_MAX_REQUESTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command side
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_data,
  // result side
  output logic                  out_strobe,
  output out_word_t             out_data,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // store holds the requests plus track 0, the head and the end track
  localparam int DEPTH = MAX_REQUESTS + 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // config registers
  logic [TRACK_W-1:0] head_r;
  logic [COUNT_W-1:0] count_r;

  // sequencer state
  seq_state_t         state_r, state_nxt;
  ins_phase_t         phase_r, phase_nxt;
  logic               last_r, last_nxt;
  logic [TRACK_W-1:0] val_r, val_nxt;     // value being inserted
  logic [AW-1:0]      ptr_r, ptr_nxt;     // hole that moves down during insertion
  logic [AW-1:0]      idx_r, idx_nxt;     // walk / search address
  logic [AW-1:0]      k_r, k_nxt;         // words issued in the walk
  logic [CW-1:0]      used_r, used_nxt;   // list length
  walk_ctl_t          rd_ctl_r, rd_ctl_nxt;

  // ram port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [TRACK_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [TRACK_W-1:0] ram_rdata;

  // derived track limits
  logic [TRACK_W-1:0] end_trk;
  logic [TRACK_W-1:0] head_trk;
  logic [TRACK_W-1:0] req_trk;
  logic [TRACK_W-1:0] cur_trk;

  // shared comparator
  logic [TRACK_W-1:0] cmp_a, cmp_b;
  logic               cmp_gt;

  // insertion bookkeeping
  logic               ins_done;
  logic               ins_begin;
  logic [TRACK_W-1:0] ins_val;
  ins_phase_t         ins_phase;
  logic [CW-1:0]      last_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAD:  head_r  <= cfg_data[TRACK_W-1:0];
        CFG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // end track: zero count acts as one track, counts past the range saturate
  always_comb begin
    if (count_r == '0) begin
      end_trk = '0;
    end else if (count_r[COUNT_W-1]) begin
      end_trk = '1;
    end else begin
      end_trk = count_r[TRACK_W-1:0] - TRACK_W'(1);
    end
    head_trk = (head_r > end_trk) ? end_trk : head_r;
    req_trk  = (in_data.request_track > end_trk) ? end_trk : in_data.request_track;
    // stored tracks are clamped again on the way out
    cur_trk  = (ram_rdata > end_trk) ? end_trk : ram_rdata;
  end

  // one compare serves both the insertion shift and the head search
  always_comb begin
    if (state_r == S_SRCH_CMP) begin
      cmp_a = head_trk;
      cmp_b = ram_rdata;
    end else begin
      cmp_a = ram_rdata;
      cmp_b = val_r;
    end
    cmp_gt = cmp_a > cmp_b;
  end

  assign last_pos = used_r - CW'(1);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    last_nxt   = last_r;
    val_nxt    = val_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    used_nxt   = used_r;
    rd_ctl_nxt = '0;
    ram_we     = 1'b0;
    ram_waddr  = ptr_r;
    ram_wdata  = val_r;
    ram_raddr  = ptr_r - AW'(1);
    ins_done   = 1'b0;
    ins_begin  = 1'b0;
    ins_val    = '0;
    ins_phase  = PH_REQ;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          last_nxt = in_data.last_request;
          if (used_r < CW'(MAX_REQUESTS)) begin
            ins_begin = 1'b1;
            ins_val   = req_trk;
            ins_phase = PH_REQ;
          end else if (in_data.last_request) begin
            // store full: request dropped, batch still goes out
            ins_begin = 1'b1;
            ins_val   = '0;
            ins_phase = PH_ZERO;
          end
        end
      end
      S_INS_START: begin
        if (ptr_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ins_done  = 1'b1;
        end else begin
          ram_raddr = ptr_r - AW'(1);
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (cmp_gt) begin
          // shift the larger entry up into the hole
          ram_wdata = ram_rdata;
          ptr_nxt   = ptr_r - AW'(1);
          ram_raddr = ptr_r - AW'(2);
          if (ptr_r == AW'(1)) begin
            state_nxt = S_INS_START;
          end
        end else begin
          ins_done = 1'b1;
        end
      end
      S_SRCH_START: begin
        ram_raddr = '0;
        idx_nxt   = '0;
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (!cmp_gt) begin
          // first entry not below the head is the head itself
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          ram_raddr = idx_r + AW'(1);
        end
      end
      S_EMIT: begin
        ram_raddr        = idx_r;
        rd_ctl_nxt.valid = 1'b1;
        rd_ctl_nxt.first = (k_r == '0);
        rd_ctl_nxt.last  = (CW'(k_r) == last_pos);
        idx_nxt          = (CW'(idx_r) == last_pos) ? '0 : idx_r + AW'(1);
        k_nxt            = k_r + AW'(1);
        if (CW'(k_r) == last_pos) begin
          used_nxt  = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ins_done) begin
      case (phase_r)
        PH_REQ: begin
          if (last_r) begin
            ins_begin = 1'b1;
            ins_val   = '0;
            ins_phase = PH_ZERO;
          end else begin
            state_nxt = S_IDLE;
          end
        end
        PH_ZERO: begin
          ins_begin = 1'b1;
          ins_val   = head_trk;
          ins_phase = PH_HEAD;
        end
        PH_HEAD: begin
          ins_begin = 1'b1;
          ins_val   = end_trk;
          ins_phase = PH_END;
        end
        PH_END: begin
          state_nxt = S_SRCH_START;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end

    // new insertion opens a hole at the top of the list
    if (ins_begin) begin
      state_nxt = S_INS_START;
      phase_nxt = ins_phase;
      val_nxt   = ins_val;
      ptr_nxt   = used_r[AW-1:0];
      used_nxt  = used_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_REQ;
      last_r   <= 1'b0;
      used_r   <= '0;
      rd_ctl_r <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      last_r   <= last_nxt;
      used_r   <= used_nxt;
      rd_ctl_r <= rd_ctl_nxt;
    end
    val_r <= val_nxt;
    ptr_r <= ptr_nxt;
    idx_r <= idx_nxt;
    k_r   <= k_nxt;
  end

  assign busy = (state_r != S_IDLE);

  cscan_ram #(
    .WIDTH (TRACK_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // distance and running total, registered into the output word
  cscan_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (rd_ctl_r),
    .cur        (cur_trk),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // list never grows past the store
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(DEPTH))
    else $error("list length beyond store depth");

  // shift step never runs with the hole at the bottom
  a_ptr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS_CMP |-> ptr_r != '0)
    else $error("insertion compare with empty prefix");

  // no walk read is in flight once idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !rd_ctl_r.valid)
    else $error("walk read pending while idle");

  // each walk read gives exactly one result word
  a_read_to_word: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ctl_r.valid |=> out_strobe)
    else $error("walk read without result word");

  // batch end empties the list
  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> used_r == '0)
    else $error("list not cleared after walk");

endmodule
